>>> design/kbsu_pkg.sv
// ----------------------------------------------------------------------------
// kbsu_pkg
// Shared types, constants and the microcode program of the binary string
// unranking block.
// ----------------------------------------------------------------------------
package kbsu_pkg;

   // Default longest string that the block answers.
   localparam int MAX_LEN_DEF = 32;

   // Field widths of the request and response words.
   localparam int CNT_W  = 6;
   localparam int LEN_W  = 7;
   localparam int RANK_W = 63;
   localparam int STR_W  = 32;

   // Binomial values up to C(62, 31) fit in 63 bits.
   localparam int BIN_W = 63;

   // Step counter width of the sequencer.
   localparam int STEP_W = 3;

   typedef struct packed {
      logic [CNT_W-1:0]  zero_count;
      logic [CNT_W-1:0]  one_count;
      logic [RANK_W-1:0] rank;
   } req_type;

   typedef struct packed {
      logic              impossible;
      logic [CNT_W-1:0]  length;
      logic [STR_W-1:0]  bit_string;
   } rsp_type;

   // Datapath operations selected by the control word.
   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_READ_TOTAL,
      OP_CHECK,
      OP_FETCH,
      OP_DECIDE,
      OP_EMIT
   } op_type;

   // Jump conditions of the sequencer.
   typedef enum logic [2:0] {
      JC_NEVER,
      JC_ALWAYS,
      JC_NO_ACCEPT,
      JC_FAIL,
      JC_STOP,
      JC_MORE,
      JC_OUT_BUSY
   } jc_type;

   typedef struct packed {
      op_type            op;
      jc_type            jc;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   // Status flags that the datapath reports to the sequencer.
   typedef struct packed {
      logic fail;
      logic stop;
      logic more;
   } dp_status_type;

   // Program addresses. The emit step directly follows the decide step so
   // that the last position falls through into it; the unused step after
   // emit returns to the wait step.
   localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_TOTAL  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_FETCH  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_DECIDE = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd5;

   // Microcode ROM: a jump is taken when its condition holds, otherwise
   // the step counter advances by one.
   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      begin
         unique case (step)
            STEP_WAIT:   w = '{op: OP_LOAD,       jc: JC_NO_ACCEPT, target: STEP_WAIT};
            STEP_TOTAL:  w = '{op: OP_READ_TOTAL, jc: JC_FAIL,      target: STEP_EMIT};
            STEP_CHECK:  w = '{op: OP_CHECK,      jc: JC_STOP,      target: STEP_EMIT};
            STEP_FETCH:  w = '{op: OP_FETCH,      jc: JC_NEVER,     target: STEP_WAIT};
            STEP_DECIDE: w = '{op: OP_DECIDE,     jc: JC_MORE,      target: STEP_FETCH};
            STEP_EMIT:   w = '{op: OP_EMIT,       jc: JC_OUT_BUSY,  target: STEP_EMIT};
            default:     w = '{op: OP_NOP,        jc: JC_ALWAYS,    target: STEP_WAIT};
         endcase
         return w;
      end
   endfunction

endpackage

>>> design/kbsu_pascal.sv
// ----------------------------------------------------------------------------
// kbsu_pascal
// Binomial table memory. After reset it builds Pascal's triangle row by row,
// then answers one registered read per cycle.
// ----------------------------------------------------------------------------
module kbsu_pascal #(
   parameter int  MAX_LEN = kbsu_pkg::MAX_LEN_DEF,
   localparam int AW      = $clog2(MAX_LEN + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [2*AW-1:0]            run_addr,
   output logic [kbsu_pkg::BIN_W-1:0] rd_data,
   output logic                       ready
);
   import kbsu_pkg::*;

   localparam int DEPTH = 1 << (2 * AW);
   localparam logic [AW-1:0] LAST_ROW = AW'(MAX_LEN);

   // Entry {n, r} holds C(n, r) for r <= n; other entries may be read but are never used.
   logic [BIN_W-1:0] mem [DEPTH];

   logic            fill_ff;
   logic            fill_in;
   logic [AW-1:0]   row_ff;
   logic [AW-1:0]   row_in;
   logic [AW-1:0]   col_ff;
   logic [AW-1:0]   col_in;
   logic            wr_valid_ff;
   logic            wr_edge_ff;
   logic [2*AW-1:0] wr_addr_ff;
   logic [2*AW-1:0] addr_a;
   logic [2*AW-1:0] addr_b;
   logic [BIN_W-1:0] rd_a_ff;
   logic [BIN_W-1:0] rd_b_ff;
   logic [BIN_W:0]   sum;

   // During the build both ports read the two parents in the row above.
   always_comb begin
      addr_a = fill_ff ? {row_ff - AW'(1), col_ff - AW'(1)} : run_addr;
      addr_b = {row_ff - AW'(1), col_ff};
      sum    = {1'b0, rd_a_ff} + {1'b0, rd_b_ff};
   end

   // Walk the triangle one entry per cycle.
   always_comb begin
      fill_in = fill_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (col_ff == row_ff) begin
         if (row_ff == LAST_ROW) begin
            fill_in = 1'b0;
         end else begin
            row_in = row_ff + AW'(1);
            col_in = '0;
         end
      end else begin
         col_in = col_ff + AW'(1);
      end
   end

   // Build control.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= 1'b1;
         row_ff      <= '0;
         col_ff      <= '0;
         wr_valid_ff <= 1'b0;
      end else begin
         if (fill_ff) begin
            fill_ff <= fill_in;
            row_ff  <= row_in;
            col_ff  <= col_in;
         end
         wr_valid_ff <= fill_ff;
      end
   end

   // Write address and edge flag are registered alongside the parent read data.
   always_ff @(posedge clock) begin
      wr_addr_ff <= {row_ff, col_ff};
      wr_edge_ff <= (col_ff == '0) || (col_ff == row_ff);
   end

   // Memory with one write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_valid_ff) begin
         mem[wr_addr_ff] <= wr_edge_ff ? BIN_W'(1) : sum[BIN_W-1:0];
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   assign rd_data = rd_a_ff;
   assign ready   = !fill_ff && !wr_valid_ff;

endmodule

>>> design/kbsu_dp.sv
// ----------------------------------------------------------------------------
// kbsu_dp
// Unranking datapath: holds the counts, the remaining rank and the string,
// and carries out the operation named by the current control word.
// ----------------------------------------------------------------------------
module kbsu_dp #(
   parameter int  MAX_LEN = kbsu_pkg::MAX_LEN_DEF,
   localparam int AW      = $clog2(MAX_LEN + 1)
) (
   input  logic                          clock,
   input  kbsu_pkg::op_type              op,
   input  logic                          accept,
   input  kbsu_pkg::req_type             req,
   input  logic [kbsu_pkg::BIN_W-1:0]    rd_data,
   output logic [2*AW-1:0]               run_addr,
   output kbsu_pkg::dp_status_type       status,
   output kbsu_pkg::rsp_type             result
);
   import kbsu_pkg::*;

   logic [CNT_W-1:0]  zeros_ff;
   logic [CNT_W-1:0]  ones_ff;
   logic [RANK_W-1:0] rank_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  rem_ff;
   logic [STR_W-1:0]  str_ff;
   logic              fail_ff;

   logic [LEN_W-1:0]  len_sum;
   logic [LEN_W-1:0]  nsub;
   logic [BIN_W-1:0]  with_zero;
   logic              take_zero;
   logic              over;

   always_comb begin
      len_sum   = {1'b0, req.zero_count} + {1'b0, req.one_count};
      nsub      = rem_ff - LEN_W'(1);
      // Completions that start with a zero: C(zeros - 1 + ones, ones).
      with_zero = (zeros_ff != '0) ? rd_data : '0;
      take_zero = (zeros_ff != '0) && (rank_ff <= with_zero);
      over      = rank_ff > rd_data;
   end

   // Table address: total count at the check, next prefix count in the loop.
   always_comb begin
      if (op == OP_FETCH) begin
         run_addr = {nsub[AW-1:0], ones_ff[AW-1:0]};
      end else begin
         run_addr = {len_ff[AW-1:0], zeros_ff[AW-1:0]};
      end
   end

   always_comb begin
      status.fail = fail_ff;
      status.stop = fail_ff || over || (rem_ff == '0);
      status.more = rem_ff != LEN_W'(1);
   end

   always_comb begin
      result.impossible = fail_ff;
      result.length     = fail_ff ? '0 : len_ff[CNT_W-1:0];
      result.bit_string = fail_ff ? '0 : str_ff;
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (op)
         OP_LOAD: begin
            if (accept) begin
               zeros_ff <= req.zero_count;
               ones_ff  <= req.one_count;
               rank_ff  <= req.rank;
               len_ff   <= len_sum;
               rem_ff   <= len_sum;
               str_ff   <= '0;
               fail_ff  <= (req.rank == '0) || (len_sum > LEN_W'(MAX_LEN));
            end
         end
         OP_CHECK: begin
            if (over) begin
               fail_ff <= 1'b1;
            end
         end
         OP_DECIDE: begin
            rem_ff <= nsub;
            if (take_zero) begin
               str_ff   <= {str_ff[STR_W-2:0], 1'b0};
               zeros_ff <= zeros_ff - CNT_W'(1);
            end else begin
               str_ff  <= {str_ff[STR_W-2:0], 1'b1};
               rank_ff <= rank_ff - with_zero;
               ones_ff <= ones_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

endmodule

>>> design/kbsu_seq.sv
// ----------------------------------------------------------------------------
// kbsu_seq
// Microcode sequencer: step counter, control word lookup and conditional
// jumps.
// ----------------------------------------------------------------------------
module kbsu_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    out_busy,
   input  kbsu_pkg::dp_status_type status,
   output kbsu_pkg::ctrl_word_type ctrl
);
   import kbsu_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              jump;

   assign ctrl = ucode(step_ff);

   // Evaluate the jump condition of the current control word.
   always_comb begin
      unique case (ctrl.jc)
         JC_NEVER:     jump = 1'b0;
         JC_ALWAYS:    jump = 1'b1;
         JC_NO_ACCEPT: jump = !accept;
         JC_FAIL:      jump = status.fail;
         JC_STOP:      jump = status.stop;
         JC_MORE:      jump = status.more;
         JC_OUT_BUSY:  jump = out_busy;
         default:      jump = 1'b1;
      endcase
      step_in = jump ? ctrl.target : step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

>>> design/kth_binary_string_unrank.sv
// ----------------------------------------------------------------------------
// kth_binary_string_unrank
// Returns the k-th binary string, in lexicographic order, with given counts
// of zeros and ones.
// ----------------------------------------------------------------------------
// Usage:
// A request word (zero_count, one_count, rank) is taken when req_valid is high
// and req_stall is low. One response word (impossible, length, bit_string)
// follows for each request; it is taken when rsp_valid is high and rsp_stall
// is low, and it holds steady while stalled.
// A microcoded sequencer walks the string one position at a time: a fetch
// step reads a binomial from the Pascal table memory, a decide step compares
// it with the remaining rank. Impossible requests skip the walk and go
// straight to the emit step. A new request is taken only after the response
// to the last one has been emitted.
// After reset the table is built, one entry per cycle, and req_stall stays
// high until it is done. While rsp_stall holds a finished word, the block
// waits in its emit step and takes no new request.
// ----------------------------------------------------------------------------
module kth_binary_string_unrank #(
   parameter int MAX_LEN = kbsu_pkg::MAX_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kbsu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kbsu_pkg::rsp_type rsp_data
);
   import kbsu_pkg::*;

   localparam int AW = $clog2(MAX_LEN + 1);

   ctrl_word_type   ctrl;
   dp_status_type   status;
   rsp_type         result;
   rsp_type         rsp_data_ff;
   logic            rsp_valid_ff;
   logic [2*AW-1:0] run_addr;
   logic [BIN_W-1:0] rd_data;
   logic            tbl_ready;
   logic            accept;
   logic            out_busy;
   logic            emit;

   // Requests are taken only in the wait step once the table is built.
   assign req_stall = !((ctrl.op == OP_LOAD) && tbl_ready);
   assign accept    = req_valid && !req_stall;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign emit      = (ctrl.op == OP_EMIT) && !out_busy;

   kbsu_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .out_busy (out_busy),
      .status   (status),
      .ctrl     (ctrl)
   );

   kbsu_pascal #(.MAX_LEN(MAX_LEN)) u_pascal (
      .clock    (clock),
      .reset    (reset),
      .run_addr (run_addr),
      .rd_data  (rd_data),
      .ready    (tbl_ready)
   );

   kbsu_dp #(.MAX_LEN(MAX_LEN)) u_dp (
      .clock    (clock),
      .op       (ctrl.op),
      .accept   (accept),
      .req      (req_data),
      .rd_data  (rd_data),
      .run_addr (run_addr),
      .status   (status),
      .result   (result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> test/kth_binary_string_unrank_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kth_binary_string_unrank_tb
// Self-checking bench for the binary string unranking block. Query words are
// sent through the request channel. A predictor computes each answer by
// exact binomial counting. Every response word is compared field by field
// with the oldest pending answer. Both channels idle in random bursts,
// except in the last phase.
// ----------------------------------------------------------------------------
module kth_binary_string_unrank_tb;
   import kbsu_pkg::*;

   localparam int MAX_LEN     = MAX_LEN_DEF;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_WAIT  = 2 * MAX_LEN + 16;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type pending_answers[$];
   int      error_count     = 0;
   int      query_count     = 0;
   int      answer_count    = 0;
   int      impossible_seen = 0;
   int      cycle_count     = 0;
   bit      idling_on       = 1'b1;

   kth_binary_string_unrank #(
      .MAX_LEN(MAX_LEN)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // Free-running clock.
   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d answers pending",
                  cycle_count, pending_answers.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Exact binomial coefficient; all values used here fit in 64 bits.
   function automatic longint unsigned binomial_count(int unsigned n, int unsigned r);
      longint unsigned c;
      int unsigned     i;
      c = 1;
      if (r > n) return 0;
      if (n - r < r) r = n - r;
      for (i = 0; i < r; i++) c = (c * longint'(n - i)) / longint'(i + 1);
      return c;
   endfunction

   // Predicts the answer word: walks the string position by position and
   // places a zero when the rank falls among the completions that start with zero.
   function automatic rsp_type unrank_string(req_type q);
      int unsigned     zeros;
      int unsigned     ones;
      int unsigned     total;
      int unsigned     pos;
      longint unsigned k;
      longint unsigned with_zero;
      logic [STR_W-1:0] str;
      rsp_type         r;
      zeros = q.zero_count;
      ones  = q.one_count;
      total = zeros + ones;
      k     = q.rank;
      str   = '0;
      r     = '0;
      if (k == 0 || total > MAX_LEN || k > binomial_count(total, zeros)) begin
         r.impossible = 1'b1;
         return r;
      end
      for (pos = 0; pos < total; pos++) begin
         with_zero = 0;
         if (zeros > 0) with_zero = binomial_count(zeros - 1 + ones, ones);
         str = str << 1;
         if (zeros > 0 && k <= with_zero) begin
            zeros--;
         end else begin
            k -= with_zero;
            str[0] = 1'b1;
            ones--;
         end
      end
      r.length     = total[CNT_W-1:0];
      r.bit_string = str;
      return r;
   endfunction

   // Full-width random rank, covering the top bit as well.
   function automatic logic [RANK_W-1:0] random_rank();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[RANK_W-1:0];
   endfunction

   task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
      error_count++;
      $display("Mismatch on answer %0d, %s: got 0x%0h, expected 0x%0h",
               answer_count, field, got, want);
   endtask

   // Sends one query word, with an optional idle burst first, and records
   // the predicted answer once the word is taken. The rank keeps its low
   // 63 bits.
   task automatic send_query(int unsigned zeros, int unsigned ones, longint unsigned k);
      req_type q;
      q.zero_count = zeros[CNT_W-1:0];
      q.one_count  = ones[CNT_W-1:0];
      q.rank       = k[RANK_W-1:0];
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
      pending_answers.push_back(unrank_string(q));
      query_count++;
   endtask

   // A well-formed query: counts that fit, rank always inside the valid range.
   task automatic send_well_formed();
      int unsigned     zeros;
      int unsigned     ones;
      longint unsigned limit;
      longint unsigned k;
      zeros = $urandom_range(0, MAX_LEN);
      ones  = $urandom_range(0, MAX_LEN - zeros);
      limit = binomial_count(zeros + ones, zeros);
      case ($urandom_range(0, 9))
         0:       k = 1;
         1:       k = limit;
         default: k = 1 + ({$urandom, $urandom} % limit);
      endcase
      send_query(zeros, ones, k);
   endtask

   // Response side: stall in random bursts while idling is on.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (idling_on) begin
            rsp_stall <= $urandom_range(0, 1);
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Compare every taken response word with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         answer_count++;
         if (rsp_data.impossible) impossible_seen++;
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected word", 64'(rsp_data), 0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.impossible !== want.impossible)
               report_mismatch("impossible", rsp_data.impossible, want.impossible);
            if (rsp_data.length !== want.length)
               report_mismatch("length", rsp_data.length, want.length);
            if (rsp_data.bit_string !== want.bit_string)
               report_mismatch("bit_string", rsp_data.bit_string, want.bit_string);
         end
      end
   end

   // Rank zero, the last rank, rank past the count, strings too long and the empty string.
   task automatic test_special_cases();
      send_query(3, 3, 0);
      send_query(3, 3, binomial_count(6, 3));
      send_query(3, 3, binomial_count(6, 3) + 1);
      send_query(0, 0, 1);
      send_query(0, 0, 2);
      send_query(0, 0, 0);
      send_query(MAX_LEN + 1, 0, 1);
      send_query(0, MAX_LEN + 1, 1);
      send_query(MAX_LEN / 2 + 1, MAX_LEN / 2, 1);
      send_query(63, 63, '1);
   endtask

   // Edges of the field ranges and the longest strings.
   task automatic test_field_extremes();
      longint unsigned middle;
      middle = binomial_count(MAX_LEN, MAX_LEN / 2);
      send_query(MAX_LEN, 0, 1);
      send_query(0, MAX_LEN, 1);
      send_query(MAX_LEN, 0, 2);
      send_query(MAX_LEN / 2, MAX_LEN / 2, 1);
      send_query(MAX_LEN / 2, MAX_LEN / 2, middle);
      send_query(MAX_LEN / 2, MAX_LEN / 2, middle + 1);
      send_query(MAX_LEN / 2, MAX_LEN / 2, '1);
      send_query(1, MAX_LEN - 1, MAX_LEN);
      send_query(MAX_LEN - 1, 1, 17);
      send_query(0, 1, 1);
      send_query(1, 0, 1);
      send_query(2, 2, 4);
   endtask

   // Mostly well-formed queries with random content, plus broken ones.
   task automatic test_random_queries(int count);
      int          n;
      int unsigned zeros;
      int unsigned ones;
      for (n = 0; n < count; n++) begin
         case ($urandom_range(0, 19))
            0: send_query($urandom_range(0, MAX_LEN), $urandom_range(0, MAX_LEN), 0);
            1: begin
               zeros = $urandom_range(0, MAX_LEN);
               ones  = $urandom_range(0, MAX_LEN - zeros);
               send_query(zeros, ones, binomial_count(zeros + ones, zeros)
                                       + $urandom_range(1, 1000));
            end
            2: begin
               zeros = $urandom_range(0, 63);
               ones  = $urandom_range(MAX_LEN + 1 - (zeros > MAX_LEN ? MAX_LEN : zeros), 63);
               send_query(zeros, ones, $urandom_range(1, 50));
            end
            default: send_well_formed();
         endcase
      end
   endtask

   // Fully random fields: almost all of these are impossible.
   task automatic test_noise(int count);
      int n;
      for (n = 0; n < count; n++)
         send_query($urandom_range(0, 63), $urandom_range(0, 63), {1'b0, random_rank()});
   endtask

   // Back-to-back words with no idling on either side.
   task automatic test_full_rate(int count);
      int n;
      idling_on = 1'b0;
      for (n = 0; n < count; n++) send_well_formed();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_special_cases();
      test_field_extremes();
      test_random_queries(1300);
      test_noise(150);
      test_full_rate(280);
      req_valid <= 1'b0;
      while (pending_answers.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Sent %0d queries, checked %0d answers (%0d impossible), %0d errors.",
               query_count, answer_count, impossible_seen, error_count);
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> kth_binary_string_unrank.f
design/kbsu_pkg.sv
design/kbsu_pascal.sv
design/kbsu_dp.sv
design/kbsu_seq.sv
design/kth_binary_string_unrank.sv
test/kth_binary_string_unrank_tb.sv
